@@ rtl/gdd_pkg.sv @@
// Shared types, constants and the month table for the Gregorian day distance core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DIST_W  = 22;
    localparam int SERIAL_W = 23;     // serial day number of years up to 16383
    localparam int RANK_W   = 9;      // day of year, up to 31 + 365 + 1
    localparam int Q100_W   = 8;      // year / 100, up to 163
    localparam int PROD_W   = 29;     // year times reciprocal of 100

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for y below 43690
    localparam logic [14:0] DIV100_MUL   = 15'd20972;
    localparam int          DIV100_SHIFT = 21;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [6:0] YEAR_HUNDRED   = 7'd100;
    localparam logic [8:0] DAYS_COMMON_YR = 9'd365;
    localparam logic [3:0] MONTHS_IN_YEAR = 4'd12;
    localparam logic [3:0] MARCH_DONE     = 4'd2;

    typedef struct packed {
        logic load;     // capture the input beat
        logic div;      // reciprocal multiply for year / 100, month table lookup
        logic year;     // leap rule and days before the year
        logic ser;      // serial day number
        logic out;      // distance into the output register
    } gdd_cmd_t;

    // Days before the start of month done+1 in a common year.
    function automatic logic [RANK_W-1:0] month_base(input logic [3:0] done);
        logic [RANK_W-1:0] base;
        begin
            case (done)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd365;
            endcase
            return base;
        end
    endfunction

endpackage

@@ rtl/gregorian_day_distance_core.sv @@
// Gregorian day distance: absolute number of days between two dates.
// A new date pair is accepted only in idle, so pairs do not overlap: each passes the
// four datapath stages (reciprocal divide by 100, leap and year count, serial sum,
// difference), and the difference stage waits while the output register is full.
// The output register lets the next pair enter while a result waits.
// Reset (rst_n, asynchronous) returns the controller to idle and drops out_valid.
`timescale 1ns / 1ps

module gregorian_day_distance_core
    import gdd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DAY_W-1:0]    first_day,
    input  logic [MONTH_W-1:0]  first_month,
    input  logic [YEAR_W-1:0]   first_year,
    input  logic [DAY_W-1:0]    second_day,
    input  logic [MONTH_W-1:0]  second_month,
    input  logic [YEAR_W-1:0]   second_year,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DIST_W-1:0]   day_distance
);

    gdd_cmd_t cmd;

    gdd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    gdd_datapath u_datapath
    (
        .clk          (clk),
        .cmd          (cmd),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .day_distance (day_distance)
    );

endmodule

@@ rtl/gdd_serial.sv @@
// Serial day number of one date, computed over three enabled register stages.
// Depends on gdd_pkg for widths, the month table and the command struct.
`timescale 1ns / 1ps

module gdd_serial
    import gdd_pkg::*;
(
    input  logic                 clk,
    input  gdd_cmd_t             cmd,
    input  logic [DAY_W-1:0]     day,
    input  logic [MONTH_W-1:0]   month,
    input  logic [YEAR_W-1:0]    year,
    output logic [SERIAL_W-1:0]  serial
);

    logic [DAY_W-1:0]    day_reg;
    logic [MONTH_W-1:0]  month_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [Q100_W-1:0]   q_reg;
    logic [RANK_W-1:0]   rank0_reg;
    logic                late_reg;
    logic [SERIAL_W-1:0] dby_reg;
    logic [RANK_W-1:0]   rank_reg;
    logic [SERIAL_W-1:0] serial_reg;

    logic [PROD_W-1:0]   prod;
    logic [3:0]          done;
    logic [YEAR_W-1:0]   hund;
    logic [YEAR_W-1:0]   rem100;
    logic                rem_nz;
    logic                leap;
    logic [Q100_W-1:0]   c100;
    logic [5:0]          c400;
    logic [12:0]         y4;
    logic [SERIAL_W-1:0] dby_next;

    assign prod = PROD_W'(year_reg) * PROD_W'(DIV100_MUL);

    // Month zero counts as January, anything past December counts the full year.
    always_comb
    begin
        if (month_reg == '0)
            done = '0;
        else
            done = month_reg - 4'd1;
        if (done > MONTHS_IN_YEAR)
            done = MONTHS_IN_YEAR;
    end

    assign hund   = YEAR_W'(q_reg) * YEAR_W'(YEAR_HUNDRED);
    assign rem100 = year_reg - hund;
    assign rem_nz = (rem100 != '0);
    assign leap   = ((year_reg[1:0] == 2'd0) && rem_nz) || (!rem_nz && (q_reg[1:0] == 2'd0));
    // Nested ceilings: ceil(y/400) = ceil(ceil(y/100) / 4)
    assign c100   = q_reg + Q100_W'(rem_nz);
    assign c400   = 6'((9'(c100) + 9'd3) >> 2);
    assign y4     = 13'((15'(year_reg) + 15'd3) >> 2);
    assign dby_next = SERIAL_W'(year_reg) * SERIAL_W'(DAYS_COMMON_YR) + SERIAL_W'(y4)
                    - SERIAL_W'(c100) + SERIAL_W'(c400);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            day_reg   <= day;
            month_reg <= month;
            year_reg  <= year;
        end
        if (cmd.div)
        begin
            q_reg     <= prod[DIV100_SHIFT +: Q100_W];
            rank0_reg <= RANK_W'(day_reg) + month_base(done);
            late_reg  <= (done >= MARCH_DONE);
        end
        if (cmd.year)
        begin
            dby_reg  <= dby_next;
            rank_reg <= rank0_reg + RANK_W'(leap && late_reg);
        end
        if (cmd.ser)
            serial_reg <= dby_reg + SERIAL_W'(rank_reg);
    end

    assign serial = serial_reg;

endmodule

@@ rtl/gdd_datapath.sv @@
// Datapath: two serial day units, absolute difference, saturation, output register.
// Depends on gdd_pkg and gdd_serial.
`timescale 1ns / 1ps

module gdd_datapath
    import gdd_pkg::*;
(
    input  logic                clk,
    input  gdd_cmd_t            cmd,
    input  logic [DAY_W-1:0]    first_day,
    input  logic [MONTH_W-1:0]  first_month,
    input  logic [YEAR_W-1:0]   first_year,
    input  logic [DAY_W-1:0]    second_day,
    input  logic [MONTH_W-1:0]  second_month,
    input  logic [YEAR_W-1:0]   second_year,
    output logic [DIST_W-1:0]   day_distance
);

    logic [SERIAL_W-1:0] serial_a;
    logic [SERIAL_W-1:0] serial_b;
    logic [SERIAL_W-1:0] diff;
    logic [DIST_W-1:0]   dist_next;
    logic [DIST_W-1:0]   dist_reg;

    gdd_serial u_serial_a
    (
        .clk    (clk),
        .cmd    (cmd),
        .day    (first_day),
        .month  (first_month),
        .year   (first_year),
        .serial (serial_a)
    );

    gdd_serial u_serial_b
    (
        .clk    (clk),
        .cmd    (cmd),
        .day    (second_day),
        .month  (second_month),
        .year   (second_year),
        .serial (serial_b)
    );

    assign diff = (serial_a >= serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);

    always_comb
    begin
        if (diff > SERIAL_W'(DIST_MAX))
            dist_next = DIST_MAX;
        else
            dist_next = diff[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out)
            dist_reg <= dist_next;
    end

    assign day_distance = dist_reg;

endmodule

@@ rtl/gdd_ctrl.sv @@
// Controller: sequences one date pair through the datapath stages and owns
// both handshakes. Depends on gdd_pkg for the command struct.
`timescale 1ns / 1ps

module gdd_ctrl
    import gdd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output gdd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_YEAR = 3'd2;
    localparam logic [2:0] ST_SER  = 3'd3;
    localparam logic [2:0] ST_DIFF = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                cmd.year   = 1'b1;
                state_next = ST_SER;
            end
            ST_SER:
            begin
                cmd.ser    = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.out    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ tb/sv/gregorian_day_distance_checker.sv @@
// Checker for the Gregorian day distance core: predicts each distance from the input beats
// and compares it with the output beats in order. Depends on gdd_pkg for the port widths.
`timescale 1ns / 1ps

module gregorian_day_distance_checker
    import gdd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [DAY_W-1:0]    first_day,
    input  logic [MONTH_W-1:0]  first_month,
    input  logic [YEAR_W-1:0]   first_year,
    input  logic [DAY_W-1:0]    second_day,
    input  logic [MONTH_W-1:0]  second_month,
    input  logic [YEAR_W-1:0]   second_year,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [DIST_W-1:0]   day_distance,
    output int                  fail_count,
    output int                  pending_count,
    output int                  checked_count
);

    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned DIST_CEILING  = (1 << DIST_W) - 1;

    logic [DIST_W-1:0] distance_q[$];

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Days from the start of year 0 through the given date.
    function automatic int unsigned date_serial(input logic [DAY_W-1:0] day,
                                                input logic [MONTH_W-1:0] mon,
                                                input logic [YEAR_W-1:0] yr);
        int unsigned month_offset [13];
        int unsigned done;
        int unsigned y;
        int unsigned rank;
        month_offset = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
        y = 32'(yr);
        done = (mon == 0) ? 0 : mon - 1;
        // months 13..15 count a whole year of earlier months
        if (done > 12)
            done = 12;
        rank = day + month_offset[done];
        if (done >= 2 && leap_year(y))
            rank++;
        return DAYS_PER_YEAR * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + rank;
    endfunction

    function automatic logic [DIST_W-1:0] predict_distance(
            input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
            input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
            input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        int unsigned a;
        int unsigned b;
        int unsigned gap;
        a = date_serial(d1, m1, y1);
        b = date_serial(d2, m2, y2);
        gap = (a >= b) ? a - b : b - a;
        // saturate, reachable only with years past the calendar range
        if (gap > DIST_CEILING)
            gap = DIST_CEILING;
        return gap[DIST_W-1:0];
    endfunction

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    always @(posedge clk)
    begin
        logic [DIST_W-1:0] want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (distance_q.size() == 0) begin
                    $display("%0t: unexpected result beat, day_distance %0d",
                             $time, day_distance);
                    fail_count++;
                end
                else begin
                    want = distance_q.pop_front();
                    checked_count++;
                    if (day_distance !== want) begin
                        $display("%0t: day_distance mismatch, expected %0d, actual %0d",
                                 $time, want, day_distance);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                distance_q.push_back(predict_distance(first_day, first_month, first_year,
                                                      second_day, second_month,
                                                      second_year));
            pending_count = distance_q.size();
        end
    end

endmodule

@@ tb/sv/gregorian_day_distance_core_test.sv @@
// Top of the Gregorian day distance testbench: clock, reset, date-pair stimulus,
// receiver stalls and the verdict. Depends on gdd_pkg, the core and the checker.
`timescale 1ns / 1ps

module gregorian_day_distance_core_test;
    import gdd_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 20;
    localparam int DATE_W       = DAY_W + MONTH_W + YEAR_W;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DIST_W-1:0]  day_distance;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_count;
    int off_calendar_count;

    gregorian_day_distance_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .day_distance (day_distance)
    );

    gregorian_day_distance_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_day     (first_day),
        .first_month   (first_month),
        .first_year    (first_year),
        .second_day    (second_day),
        .second_month  (second_month),
        .second_year   (second_year),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .day_distance  (day_distance),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", pending_count);
        $display("FAIL gregorian_day_distance_core");
        $finish;
    end

    // Receiver: switch at random between four stall patterns.
    int  rx_left = 0;
    int  rx_mode = 0;
    int  rx_hold = 0;
    int  rx_cycle = 0;
    bit  rx_stalled = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(50, 300);
            end
            rx_left--;
            rx_cycle++;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2:
                begin
                    // alternate long stalls with short ready windows
                    if (rx_hold == 0) begin
                        rx_stalled = !rx_stalled;
                        rx_hold = rx_stalled ? $urandom_range(1, 24) : $urandom_range(1, 4);
                    end
                    rx_hold--;
                    out_ready <= !rx_stalled;
                end
                default: out_ready <= (rx_cycle % 3) != 0;
            endcase
        end
    end

    // Drive one date pair and hold it until the beat is taken; returns at the next
    // falling edge with valid still high.
    task automatic send_dates(input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
                              input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
                              input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        in_valid     <= 1'b1;
        first_day    <= d1;
        first_month  <= m1;
        first_year   <= y1;
        second_day   <= d2;
        second_month <= m2;
        second_year  <= y2;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        if (d1 == 0 || m1 == 0 || m1 > 12 || y1 == 0 || y1 > 9999 ||
            d2 == 0 || m2 == 0 || m2 > 12 || y2 == 0 || y2 > 9999)
            off_calendar_count++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic random_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                               output logic [YEAR_W-1:0] y);
        d = DAY_W'($urandom_range(1, 31));
        m = MONTH_W'($urandom_range(1, 12));
        y = YEAR_W'($urandom_range(1, 9999));
    endtask

    initial
    begin
        logic [DAY_W-1:0]   d1, d2;
        logic [MONTH_W-1:0] m1, m2;
        logic [YEAR_W-1:0]  y1, y2;
        int burst;
        int kind;
        int hold_off;

        sent_count = 0;
        off_calendar_count = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        first_day    = '0;
        first_month  = '0;
        first_year   = '0;
        second_day   = '0;
        second_month = '0;
        second_year  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed pairs
        send_dates(5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd1);
        send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999);
        send_dates(5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1);
        send_dates(5'd31, 4'd12, 14'd2023, 5'd1, 4'd1, 14'd2024);
        send_dates(5'd28, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000);
        send_dates(5'd29, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900);
        send_dates(5'd30, 4'd2, 14'd2001, 5'd2, 4'd3, 14'd2001);
        send_dates(5'd0, 4'd1, 14'd1999, 5'd31, 4'd1, 14'd1999);
        send_dates(5'd15, 4'd0, 14'd1600, 5'd15, 4'd1, 14'd1600);
        send_dates(5'd1, 4'd13, 14'd1996, 5'd1, 4'd1, 14'd1997);
        send_dates(5'd31, 4'd15, 14'd2004, 5'd1, 4'd12, 14'd2004);
        idle_cycles(3);
        send_dates(5'd1, 4'd1, 14'd0, 5'd1, 4'd3, 14'd0);
        send_dates(5'd1, 4'd1, 14'd0, 5'd31, 4'd15, 14'd16383);
        send_dates(5'd31, 4'd15, 14'd16383, 5'd0, 4'd0, 14'd0);
        send_dates(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383);
        send_dates(5'd1, 4'd1, 14'd10000, 5'd1, 4'd1, 14'd9999);
        send_dates(5'd1, 4'd3, 14'd100, 5'd1, 4'd3, 14'd400);
        send_dates(5'd31, 4'd12, 14'd399, 5'd1, 4'd1, 14'd401);
        send_dates(5'd17, 4'd8, 14'd1987, 5'd3, 4'd11, 14'd1987);
        send_dates(5'd3, 4'd11, 14'd1987, 5'd17, 4'd8, 14'd1987);
        idle_cycles(7);

        for (int i = 0; i < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 16);
            for (int j = 0; j < burst && i < RANDOM_ITEMS; j++, i++)
            begin
                kind = $urandom_range(0, 99);
                random_date(d1, m1, y1);
                random_date(d2, m2, y2);
                if (kind < 55) begin
                    // plain calendar dates, already drawn
                end
                else if (kind < 75) begin
                    // same or neighboring years
                    y2 = YEAR_W'((y1 > 9996) ? y1 - $urandom_range(0, 2)
                                             : y1 + $urandom_range(0, 2));
                end
                else if (kind < 85) begin
                    // around the end of February in century and leap years
                    y1 = YEAR_W'($urandom_range(0, 99) * 100 + ($urandom_range(0, 1) ? 0 : 4));
                    y2 = YEAR_W'(y1 + $urandom_range(0, 1) * 400);
                    m1 = MONTH_W'($urandom_range(2, 3));
                    m2 = MONTH_W'($urandom_range(2, 3));
                    d1 = DAY_W'($urandom_range(27, 30));
                    d2 = DAY_W'($urandom_range(1, 29));
                end
                else begin
                    // raw field bits, off-calendar values included
                    {d1, m1, y1} = DATE_W'($urandom);
                    {d2, m2, y2} = DATE_W'($urandom);
                end
                send_dates(d1, m1, y1, d2, m2, y2);
            end
            // long stretches with no gap now and then
            hold_off = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            idle_cycles(hold_off);
        end
        idle_cycles(1);

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d date pairs, %0d with a field outside the calendar range.",
                 sent_count, off_calendar_count);
        $display("Compared %0d day distances against the prediction.", checked_count);
        if (fail_count == 0 && pending_count == 0)
            $display("PASS gregorian_day_distance_core");
        else
            $display("FAIL gregorian_day_distance_core");
        $finish;
    end

endmodule

@@ gregorian_day_distance_core.f @@
rtl/gdd_pkg.sv
rtl/gdd_serial.sv
rtl/gdd_datapath.sv
rtl/gdd_ctrl.sv
rtl/gregorian_day_distance_core.sv
tb/sv/gregorian_day_distance_checker.sv
tb/sv/gregorian_day_distance_core_test.sv
